@@ rtl/osess_pkg.sv @@
`timescale 1ns / 1ps

package osess_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUR_W  = 17;

	localparam logic [TIME_W-1:0] HEARTBEAT_RESET = 32'd300000;
	localparam logic [TIME_W-1:0] GRACE_RESET     = 32'd180000;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SITTING = 2'd1,
		MODE_GRACE   = 2'd2
	} osess_mode_t;

	typedef enum logic [1:0] {
		EV_START     = 2'd0,
		EV_HEARTBEAT = 2'd1,
		EV_END       = 2'd2
	} osess_event_t;

	typedef enum logic {
		REG_HEARTBEAT = 1'b0,
		REG_GRACE     = 1'b1
	} osess_reg_t;

	typedef struct packed {
		logic [TIME_W-1:0] heartbeat_ms;
		logic [TIME_W-1:0] grace_ms;
	} osess_cfg_t;

	typedef struct packed {
		logic              has_result;
		osess_event_t      kind;
		logic [DUR_W-1:0]  dur_mins;
	} osess_result_t;

endpackage

@@ rtl/occupancy_session_tracker_top.sv @@
`timescale 1ns / 1ps

// Desk occupancy session tracker. Each input transaction is one poll sample
// (motion level in tdata bit 0, millisecond timestamp above it); the block
// emits zero or one event per sample: session start (zero minutes), heartbeat
// with whole minutes since start, or session end. Samples are taken one per
// clock while the input is not stalled, and each event is presented on the
// output from the result register: the sample sits in the input register while
// the mode update, the wrapped time compares and the divide by 60000 (a single
// reciprocal multiply) work on it, and the result register is loaded when the
// sample moves on. Input stalls only while the result register is full and not
// taken and the sample in the input register has an event of its own.
// Registers: index 0 heartbeat interval, index 1 grace period, both in ms; the
// user writes them only while no sample is in flight; not enforced by the block.
module occupancy_session_tracker_top
	import osess_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // motion, now_ms, zero pad

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // session minutes, zero pad
	output logic [1:0]  m_axis_tuser,  // event_kind

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	osess_cfg_t    cfg;
	osess_result_t result;

	logic              valid_s1;
	logic              motion_s1;
	logic [TIME_W-1:0] now_s1;
	logic              advance;

	logic              out_valid_q;
	osess_event_t      kind_q;
	logic [DUR_W-1:0]  dur_q;

	assign cfg_ready = 1'b1;

	osess_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (osess_reg_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// samples without an event move on even when the output is blocked
	assign advance = valid_s1 && (!result.has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			motion_s1 <= s_axis_tdata[0];
			now_s1    <= s_axis_tdata[TIME_W:1];
		end
	end

	osess_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (advance),
		.motion    (motion_s1),
		.now_ms    (now_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.has_result) begin
			kind_q <= result.kind;
			dur_q  <= result.dur_mins;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {(24 - DUR_W)'(0), dur_q};

endmodule

@@ rtl/osess_cfg.sv @@
`timescale 1ns / 1ps

module osess_cfg
	import osess_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  osess_reg_t        wr_index,
	input  logic [TIME_W-1:0] wr_data,
	output osess_cfg_t        cfg
);

	logic [TIME_W-1:0] heartbeat_q;
	logic [TIME_W-1:0] grace_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heartbeat_q <= HEARTBEAT_RESET;
			grace_q     <= GRACE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_HEARTBEAT: heartbeat_q <= wr_data;
				REG_GRACE:     grace_q     <= wr_data;
				default:       ;
			endcase
		end
	end

	assign cfg.heartbeat_ms = heartbeat_q;
	assign cfg.grace_ms     = grace_q;

endmodule

@@ rtl/osess_min_div.sv @@
`timescale 1ns / 1ps

module osess_min_div
	import osess_pkg::*;
(
	input  logic [TIME_W-1:0] elapsed_ms,
	output logic [DUR_W-1:0]  mins
);

	// 60000 = 32 * 1875, the remaining divide is an exact reciprocal multiply
	localparam int unsigned PRE_SHIFT = 5;
	localparam int unsigned X_W       = TIME_W - PRE_SHIFT;
	localparam int unsigned RECIP_W   = 28;
	localparam int unsigned POST_SHIFT = 38;
	localparam int unsigned PROD_W    = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 28'd146601551;

	logic [X_W-1:0]    x;
	logic [PROD_W-1:0] prod;

	assign x    = elapsed_ms[TIME_W-1:PRE_SHIFT];
	assign prod = PROD_W'(x) * PROD_W'(RECIP);
	assign mins = prod[POST_SHIFT+DUR_W-1:POST_SHIFT];

endmodule

@@ rtl/osess_fsm.sv @@
`timescale 1ns / 1ps

module osess_fsm
	import osess_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_fire,
	input  logic              motion,
	input  logic [TIME_W-1:0] now_ms,
	input  osess_cfg_t        cfg,
	output osess_result_t     result
);

	osess_mode_t       mode_q, mode_d;
	logic [TIME_W-1:0] start_q, start_d;
	logic [TIME_W-1:0] last_q, last_d;
	logic [TIME_W-1:0] grace_q, grace_d;

	logic [TIME_W-1:0] since_start;
	logic [TIME_W-1:0] since_report;
	logic [TIME_W-1:0] since_grace;
	logic              hb_due;
	logic              grace_due;
	logic [DUR_W-1:0]  mins;

	assign since_start  = now_ms - start_q;
	assign since_report = now_ms - last_q;
	assign since_grace  = now_ms - grace_q;
	assign hb_due       = since_report >= cfg.heartbeat_ms;
	assign grace_due    = since_grace >= cfg.grace_ms;

	osess_min_div u_div (
		.elapsed_ms (since_start),
		.mins       (mins)
	);

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		last_d  = last_q;
		grace_d = grace_q;
		case (mode_q)
			MODE_SITTING: begin
				if (!motion) begin
					grace_d = now_ms;
					mode_d  = MODE_GRACE;
				end else if (hb_due) begin
					last_d = now_ms;
				end
			end
			MODE_GRACE: begin
				if (motion) begin
					mode_d = MODE_SITTING;
				end else if (grace_due) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				// idle, and the unused code behaves the same
				if (motion) begin
					start_d = now_ms;
					last_d  = now_ms;
					mode_d  = MODE_SITTING;
				end else begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		result.has_result = 1'b0;
		result.kind       = EV_START;
		result.dur_mins   = mins;
		case (mode_q)
			MODE_SITTING: begin
				result.has_result = motion && hb_due;
				result.kind       = EV_HEARTBEAT;
			end
			MODE_GRACE: begin
				result.has_result = !motion && grace_due;
				result.kind       = EV_END;
			end
			default: begin
				result.has_result = motion;
				result.kind       = EV_START;
				result.dur_mins   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			last_q  <= '0;
			grace_q <= '0;
		end else if (item_fire) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			last_q  <= last_d;
			grace_q <= grace_d;
		end
	end

endmodule

@@ rtl/osess_checker.sv @@
`timescale 1ns / 1ps

module osess_checker
	import osess_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == EV_START || m_axis_tuser == EV_HEARTBEAT ||
			m_axis_tuser == EV_END))
		else $error("unknown event kind");

	// start events always report zero minutes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_START |-> m_axis_tdata == '0)
		else $error("start event with nonzero duration");

	// durations never exceed the 32-bit range in minutes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= 24'd71582)
		else $error("duration out of range");

endmodule

bind occupancy_session_tracker_top osess_checker u_osess_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import osess_pkg::*;

	localparam int  DRAIN_CYCLES  = 8;
	localparam int  ITEMS_PER_SET = 142;
	localparam int  RAND_SETS     = 6;
	localparam time RUN_LIMIT     = 2_000_000;

	typedef struct {
		osess_event_t     kind;
		logic [DUR_W-1:0] mins;
	} sess_event_t;

	typedef enum {ROW_SAMPLE, ROW_TIMING} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [TIME_W-1:0] hb;
		logic [TIME_W-1:0] grace;
		logic              motion;
		logic [TIME_W-1:0] now;
		bit                fixed;
		bit                has;
		sess_event_t       ev;
	} stim_row_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // motion, now_ms, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // session minutes, zero pad
	logic [1:0]  m_axis_tuser;        // event_kind
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = REG_HEARTBEAT;
	logic [31:0] cfg_data      = '0;

	// event fixed by the stimulus row, travels with the sample
	bit          row_fixed     = 1'b0;
	bit          row_has       = 1'b0;
	sess_event_t row_ev        = '{EV_START, '0};

	// tracker shadow state
	osess_mode_t       trk_mode    = MODE_IDLE;
	logic [TIME_W-1:0] sess_start  = '0;
	logic [TIME_W-1:0] last_beat   = '0;
	logic [TIME_W-1:0] grace_start = '0;
	logic [TIME_W-1:0] hb_ms       = HEARTBEAT_RESET;
	logic [TIME_W-1:0] grace_ms    = GRACE_RESET;

	sess_event_t event_q[$];
	stim_row_t   rows[$];
	int          err_cnt    = 0;
	int          burst_left = 0;
	rx_style_t   rx_style   = RX_OPEN;
	int          rx_left    = 0;

	occupancy_session_tracker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [DUR_W-1:0] mins_since_start(logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - sess_start;
		return DUR_W'(elapsed / 32'd60000);
	endfunction

	// advances the shadow tracker by one poll sample
	function automatic bit track_sample(logic motion, logic [TIME_W-1:0] now,
			output sess_event_t ev);
		ev = '{EV_START, '0};
		case (trk_mode)
			MODE_SITTING: begin
				if (!motion) begin
					grace_start = now;
					trk_mode    = MODE_GRACE;
					return 1'b0;
				end
				if (now - last_beat >= hb_ms) begin
					ev        = '{EV_HEARTBEAT, mins_since_start(now)};
					last_beat = now;
					return 1'b1;
				end
				return 1'b0;
			end
			MODE_GRACE: begin
				if (motion) begin
					trk_mode = MODE_SITTING;
					return 1'b0;
				end
				if (now - grace_start >= grace_ms) begin
					ev       = '{EV_END, mins_since_start(now)};
					trk_mode = MODE_IDLE;
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				trk_mode = MODE_IDLE;
				if (motion) begin
					sess_start = now;
					last_beat  = now;
					trk_mode   = MODE_SITTING;
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		sess_event_t ev;
		bit          has;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			has = track_sample(s_axis_tdata[0], s_axis_tdata[32:1], ev);
			if (row_fixed) begin
				has = row_has;
				ev  = row_ev;
			end
			if (has)
				event_q.push_back(ev);
		end
	end

	always @(posedge clk) begin
		sess_event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (event_q.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual kind %0d mins %0d",
					$time, m_axis_tuser, m_axis_tdata[DUR_W-1:0]);
				err_cnt++;
			end else begin
				want = event_q.pop_front();
				if (m_axis_tuser !== want.kind) begin
					$display("%0t: event_kind expected %0d actual %0d",
						$time, want.kind, m_axis_tuser);
					err_cnt++;
				end
				if (m_axis_tdata[DUR_W-1:0] !== want.mins) begin
					$display("%0t: minutes expected %0d actual %0d",
						$time, want.mins, m_axis_tdata[DUR_W-1:0]);
					err_cnt++;
				end
			end
		end
	end

	// receiver backpressure, in runs of a randomly chosen style
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 3));
			rx_left  <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_style)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= ~m_axis_tready;
		endcase
	end

	function automatic void add_sample(logic motion, logic [TIME_W-1:0] now);
		rows.push_back('{ROW_SAMPLE, '0, '0, motion, now, 1'b0, 1'b0, '{EV_START, '0}});
	endfunction

	function automatic void add_fixed(logic motion, logic [TIME_W-1:0] now, bit has,
			osess_event_t kind, logic [DUR_W-1:0] mins);
		rows.push_back('{ROW_SAMPLE, '0, '0, motion, now, 1'b1, has, '{kind, mins}});
	endfunction

	function automatic void add_timing(logic [TIME_W-1:0] hb, logic [TIME_W-1:0] grace);
		rows.push_back('{ROW_TIMING, hb, grace, 1'b0, '0, 1'b0, 1'b0, '{EV_START, '0}});
	endfunction

	// sender works in bursts; valid stays high across back-to-back transactions
	task automatic send_sample(stim_row_t r);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, r.now, r.motion};
		row_fixed     <= r.fixed;
		row_has       <= r.has;
		row_ev        <= r.ev;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (event_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers in one pass, valid held high between them
	task automatic set_timing(logic [TIME_W-1:0] hb, logic [TIME_W-1:0] grace);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HEARTBEAT;
		cfg_data  <= hb;
		do @(posedge clk); while (!cfg_ready);
		hb_ms     = hb;
		cfg_index <= REG_GRACE;
		cfg_data  <= grace;
		do @(posedge clk); while (!cfg_ready);
		grace_ms  = grace;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] next_step();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return 32'd1;
			2, 3:    return $urandom_range(0, 400000);
			4:       return hb_ms;
			5:       return hb_ms - 32'd1;
			6:       return grace_ms;
			7:       return grace_ms + 32'd1;
			8:       return $urandom;
			9:       return grace_ms - 32'd1;
			10:      return hb_ms + 32'd1;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	initial begin
		logic [TIME_W-1:0] set_hb[RAND_SETS];
		logic [TIME_W-1:0] set_grace[RAND_SETS];
		logic [TIME_W-1:0] clock_ms;
		stim_row_t         r;
		bit                level;
		int                run_left;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: 300000 ms heartbeat, 180000 ms grace
		add_fixed(1'b0, 32'd0, 1'b0, EV_START, '0);
		add_fixed(1'b1, 32'd1000, 1'b1, EV_START, '0);
		add_sample(1'b1, 32'd300999);
		add_sample(1'b1, 32'd301000);
		add_sample(1'b0, 32'd301001);
		add_sample(1'b1, 32'd302000);
		add_sample(1'b0, 32'd303000);
		add_sample(1'b0, 32'd482999);
		add_sample(1'b0, 32'd483000);
		// start on the last timestamp, heartbeat across the wrap, then time going back
		add_fixed(1'b1, 32'hFFFF_FFFF, 1'b1, EV_START, '0);
		add_sample(1'b1, 32'd299999);
		add_sample(1'b1, 32'd0);
		add_sample(1'b0, 32'd5);
		add_sample(1'b0, 32'd4);
		// longest possible duration
		add_fixed(1'b1, 32'd0, 1'b1, EV_START, '0);
		add_sample(1'b1, 32'hFFFF_FFFF);
		add_sample(1'b0, 32'hFFFF_FFFF);
		add_sample(1'b0, 32'd179999);
		// zero interval and zero grace
		add_timing(32'd0, 32'd0);
		add_fixed(1'b1, 32'd100, 1'b1, EV_START, '0);
		add_sample(1'b1, 32'd100);
		add_sample(1'b0, 32'd100);
		add_sample(1'b0, 32'd100);
		// largest interval and grace
		add_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_fixed(1'b1, 32'd1, 1'b1, EV_START, '0);
		add_sample(1'b1, 32'd0);
		add_sample(1'b0, 32'd7);
		add_sample(1'b0, 32'd6);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_TIMING) begin
				wait_idle();
				set_timing(r.hb, r.grace);
			end else begin
				send_sample(r);
			end
		end

		set_hb    = '{32'd1, 32'd60000, 32'd0, 32'hFFFF_FFFF, 32'd300000, 32'd0};
		set_grace = '{32'd0, 32'd30000, 32'd1, 32'hFFFF_FFFF, 32'd180000, 32'd0};
		set_hb[RAND_SETS-1]    = $urandom_range(1, 500000);
		set_grace[RAND_SETS-1] = $urandom_range(0, 500000);

		clock_ms = $urandom;
		level    = 1'b0;
		run_left = 0;
		r        = '{ROW_SAMPLE, '0, '0, 1'b0, '0, 1'b0, 1'b0, '{EV_START, '0}};
		for (int s = 0; s < RAND_SETS; s++) begin
			wait_idle();
			set_timing(set_hb[s], set_grace[s]);
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				// sessions are runs of motion and stillness, with some noise mixed in
				if (run_left == 0) begin
					level    = ~level;
					run_left = $urandom_range(1, 12);
				end
				run_left--;
				r.motion = level;
				if ($urandom_range(0, 9) == 0)
					r.motion = 1'($urandom_range(0, 1));
				clock_ms += next_step();
				r.now    = clock_ms;
				send_sample(r);
			end
		end

		wait_idle();
		if (err_cnt == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("%0t: timeout, %0d events still expected", $time, event_q.size());
		$display("tb_top: errors");
		$finish;
	end

endmodule
